// ===== hw/rtl/lsk_pkg.sv =====
// shared types and fixed widths for the longest-sum-k sliding window unit
// no dependencies; used by the top level, the output stage and the checker
`default_nettype none

package lsk_pkg;

  localparam int unsigned LEN_BITS    = 11;
  localparam int unsigned TARGET_BITS = 32;
  localparam int unsigned TOTAL_BITS  = 33;

  typedef struct packed {
    logic [LEN_BITS-1:0] longest_length;
    logic                window_overflow;
  } result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/lsk_win_mem.sv =====
// window store: one write port, one read port with registered read data
// no dependencies
`default_nettype none

module lsk_win_mem #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned WIDTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/lsk_out_stage.sv =====
// result register between the window sequencer and the out_ channel
// depends on lsk_pkg (result_t)
`default_nettype none

module lsk_out_stage (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       load,
  input  wire lsk_pkg::result_t           load_data,
  output logic                            free,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [lsk_pkg::LEN_BITS-1:0]    out_longest_length,
  output logic                            out_window_overflow
);

  logic             valid_r;
  lsk_pkg::result_t data_r;

  // slot can take a new result when empty or being drained this cycle
  assign free = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= load_data;
    end
  end

  assign out_valid           = valid_r;
  assign out_longest_length  = data_r.longest_length;
  assign out_window_overflow = data_r.window_overflow;

endmodule

`default_nettype wire

// ===== hw/rtl/longest_sum_k_sliding_window_unit.sv =====
// longest run summing to target_sum, two-pointer window over a circular store
// a beat passes S_FULL_SUB (only when the store is full on arrival), then S_POP, with an S_POP_SUB
//   for each element dropped from the oldest end (one store read and one subtract each); a final
//   beat then waits in S_EMIT for a free output slot; in_ready is high only in S_IDLE
// reset: synchronous, active low; pointers, totals and flags clear, target_sum to 0,
//   store contents stay undefined and are never read outside the window
`default_nettype none

module longest_sum_k_sliding_window_unit #(
  parameter int unsigned WINDOW_DEPTH = 1024,
  parameter int unsigned ELEMENT_BITS = 16
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [lsk_pkg::TARGET_BITS-1:0]  cfg_wdata,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [15:0]                      in_element_value,
  input  wire logic                             in_is_final,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic [lsk_pkg::LEN_BITS-1:0]          out_longest_length,
  output logic                                  out_window_overflow
);

  localparam int unsigned AW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int unsigned CW = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned TB = lsk_pkg::TOTAL_BITS;

  typedef enum logic [4:0] {
    S_IDLE     = 5'b00001,
    S_FULL_SUB = 5'b00010,
    S_POP      = 5'b00100,
    S_POP_SUB  = 5'b01000,
    S_EMIT     = 5'b10000
  } state_t;

  function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] p);
    next_slot = (p == AW'(WINDOW_DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  state_t                        state_r, state_nxt;
  logic [ELEMENT_BITS-1:0]       elem_r, elem_nxt;
  logic                          last_r, last_nxt;
  logic [AW-1:0]                 oldest_r, oldest_nxt;
  logic [AW-1:0]                 newest_r, newest_nxt;
  logic [CW-1:0]                 count_r, count_nxt;
  logic [TB-1:0]                 total_r, total_nxt;
  logic [CW-1:0]                 best_r, best_nxt;
  logic                          ovf_r, ovf_nxt;
  logic [lsk_pkg::TARGET_BITS-1:0] target_r;

  logic                          wr_en, rd_en;
  logic [ELEMENT_BITS-1:0]       wr_data, rd_data;
  logic [ELEMENT_BITS-1:0]       elem_in;
  logic                          in_fire, full, need_pop, match;
  logic                          out_free, out_load;
  lsk_pkg::result_t              result;

  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign elem_in  = ELEMENT_BITS'(in_element_value);
  assign full     = (count_r == CW'(WINDOW_DEPTH));
  assign need_pop = (count_r != '0) && (total_r > TB'(target_r));
  assign match    = (total_r == TB'(target_r)) && (count_r > best_r);

  assign result.longest_length  = lsk_pkg::LEN_BITS'(best_r);
  assign result.window_overflow = ovf_r;

  always_comb begin
    state_nxt  = state_r;
    elem_nxt   = elem_r;
    last_nxt   = last_r;
    oldest_nxt = oldest_r;
    newest_nxt = newest_r;
    count_nxt  = count_r;
    total_nxt  = total_r;
    best_nxt   = best_r;
    ovf_nxt    = ovf_r;
    wr_en      = 1'b0;
    wr_data    = elem_in;
    rd_en      = 1'b0;
    out_load   = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          elem_nxt = elem_in;
          last_nxt = in_is_final;
          if (full) begin
            // oldest slot is also the write slot: read it out before overwriting
            rd_en     = 1'b1;
            state_nxt = S_FULL_SUB;
          end else begin
            wr_en      = 1'b1;
            newest_nxt = next_slot(newest_r);
            count_nxt  = count_r + CW'(1);
            total_nxt  = total_r + TB'(elem_in);
            state_nxt  = S_POP;
          end
        end
      end
      S_FULL_SUB: begin
        wr_en      = 1'b1;
        wr_data    = elem_r;
        newest_nxt = next_slot(newest_r);
        oldest_nxt = next_slot(oldest_r);
        total_nxt  = total_r - TB'(rd_data) + TB'(elem_r);
        ovf_nxt    = 1'b1;
        state_nxt  = S_POP;
      end
      S_POP: begin
        if (need_pop) begin
          rd_en     = 1'b1;
          state_nxt = S_POP_SUB;
        end else begin
          if (match) begin
            best_nxt = count_r;
          end
          state_nxt = last_r ? S_EMIT : S_IDLE;
        end
      end
      S_POP_SUB: begin
        total_nxt  = total_r - TB'(rd_data);
        oldest_nxt = next_slot(oldest_r);
        count_nxt  = count_r - CW'(1);
        state_nxt  = S_POP;
      end
      S_EMIT: begin
        if (out_free) begin
          out_load   = 1'b1;
          oldest_nxt = '0;
          newest_nxt = '0;
          count_nxt  = '0;
          total_nxt  = '0;
          best_nxt   = '0;
          ovf_nxt    = 1'b0;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      oldest_r <= '0;
      newest_r <= '0;
      count_r  <= '0;
      total_r  <= '0;
      best_r   <= '0;
      ovf_r    <= 1'b0;
      target_r <= '0;
    end else begin
      state_r  <= state_nxt;
      oldest_r <= oldest_nxt;
      newest_r <= newest_nxt;
      count_r  <= count_nxt;
      total_r  <= total_nxt;
      best_r   <= best_nxt;
      ovf_r    <= ovf_nxt;
      if (cfg_we) begin
        target_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    elem_r <= elem_nxt;
    last_r <= last_nxt;
  end

  lsk_win_mem #(
    .DEPTH (WINDOW_DEPTH),
    .WIDTH (ELEMENT_BITS)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (newest_r),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (oldest_r),
    .rd_data (rd_data)
  );

  lsk_out_stage u_out (
    .clk                 (clk),
    .rst_n               (rst_n),
    .load                (out_load),
    .load_data           (result),
    .free                (out_free),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_longest_length  (out_longest_length),
    .out_window_overflow (out_window_overflow)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/lsk_checker.sv =====
// port-level checks for longest_sum_k_sliding_window_unit, bound to the top level
// depends on lsk_pkg (LEN_BITS)
`default_nettype none

module lsk_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_valid,
  input wire logic                          in_ready,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic [lsk_pkg::LEN_BITS-1:0]  out_longest_length,
  input wire logic                          out_window_overflow
);

  // a stalled result beat holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_longest_length)
      && $stable(out_window_overflow))
    else $error("result beat changed while stalled");

  // every accepted beat leaves the sequencer busy in the next cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken on back-to-back cycles");

  // a new result only follows a cycle in which the input side was busy
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without a finished final beat");

  // no result right after reset
  assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result valid out of reset");

endmodule

bind longest_sum_k_sliding_window_unit lsk_checker u_lsk_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_valid),
  .in_ready            (in_ready),
  .out_valid           (out_valid),
  .out_ready           (out_ready),
  .out_longest_length  (out_longest_length),
  .out_window_overflow (out_window_overflow)
);

`default_nettype wire
